>>> sv/zcsg_pkg.sv
// Shared types, register indexes and reset constants of the Zadoff-Chu generator.
// Also holds the elaboration-time quarter-wave phasor table builder.
// Depends on nothing; used by zadoff_chu_sequence_generator_core.
package zcsg_pkg;

	// Configuration port
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_SEQ_LENGTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROOT_INDEX   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CYCLIC_SHIFT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN  = 3'd4;

	// Field widths fixed by the register map and the sample format
	localparam int unsigned LEN_W = 13;
	localparam int unsigned IDX_W = 12;
	localparam int unsigned GAIN_W = 8;
	localparam int unsigned OUT_W = 16;
	localparam int unsigned TERM_W = 14;
	localparam int unsigned PROD_W = 25;

	localparam logic [LEN_W-1:0] MAX_LEN = 13'd4096;
	localparam logic [LEN_W-1:0] SEQ_LEN_RESET = 13'd63;
	localparam logic [IDX_W-1:0] ROOT_RESET = 12'd25;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd1;

	localparam longint unsigned DIVIDEND = 64'd1 << 31;
	localparam logic [31:0] LQ_RESET = 32'(DIVIDEND / SEQ_LEN_RESET);

	// pi in Q30 and the Taylor term divisors for cosine and sine
	localparam longint unsigned PI_Q30 = 64'd3373259426;
	localparam int unsigned TAYLOR_TERMS = 12;
	localparam longint unsigned TAYLOR_DIV_C [TAYLOR_TERMS] =
		'{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
		  64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552};
	localparam longint unsigned TAYLOR_DIV_S [TAYLOR_TERMS] =
		'{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
		  64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};

	// Sideband that rides along the chip pipeline with each sample
	typedef struct packed {
		logic wrap;
		logic restart;
		logic last;
	} zcsg_ctl_t;

	// Rounds a nonnegative Q30 value to Q15, clamped to 32767.
	function automatic logic [14:0] zcsg_q30_to_q15(input longint v);
		longint r;
		begin
			if (v < 0) begin
				r = 0;
			end else begin
				r = (v + 64'sd16384) >>> 15;
			end
			if (r > 64'sd32767) begin
				r = 64'sd32767;
			end
			return r[14:0];
		end
	endfunction

	// Entry k of the first quadrant: {sin, cos} in Q15, both nonnegative.
	function automatic logic [29:0] zcsg_quarter_entry(input int unsigned k,
			input int unsigned addr_bits);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned tc;
		longint unsigned ts;
		longint sc;
		longint ss;
		begin
			x = (PI_Q30 * 64'(k)) >> (addr_bits - 1);
			x2 = (x * x) >> 30;
			tc = 64'd1 << 30;
			ts = x;
			sc = 0;
			ss = 0;
			for (int j = 0; j < TAYLOR_TERMS; j++) begin
				if ((j % 2) == 0) begin
					sc = sc + longint'(tc);
					ss = ss + longint'(ts);
				end else begin
					sc = sc - longint'(tc);
					ss = ss - longint'(ts);
				end
				tc = ((tc * x2) >> 30) / TAYLOR_DIV_C[j];
				ts = ((ts * x2) >> 30) / TAYLOR_DIV_S[j];
			end
			return {zcsg_q30_to_q15(ss), zcsg_q30_to_q15(sc)};
		end
	endfunction

endpackage

>>> sv/zcsg_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and updates only when rd_en is high. No dependencies.
module zcsg_ram #(
	parameter int unsigned WIDTH = 30,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> sv/zadoff_chu_sequence_generator_core.sv
// Zadoff-Chu sequence generator core. Every input beat is one sample tick and
// yields exactly one output beat carrying the currently held I/Q phasor; the
// sustained rate is one beat per clock while the output register handshake
// and s_tready allow it, and a beat is registered through the registers s1 to s6
// into the output register. A 32-bit phase accumulator adds phase_step on each
// tick; when it wraps, the symbol index steps modulo the sequence length L and
// a new chip is formed through a chain of registered multipliers, a read of the
// phasor RAM and a gain stage. After reset the block loads the quarter-wave
// phasor RAM, one entry a cycle, 2^(ROM_ADDR_BITS-2) entries (256 at the default
// size), before s_tready rises. A write of seq_length starts a shared
// shift-subtract divider that reduces the symbol index modulo the new length and
// then forms floor(2^31/L); s_tready stays low while it runs. Other register
// writes take effect at once. Depends on zcsg_pkg and zcsg_ram.
module zadoff_chu_sequence_generator_core #(
	parameter int unsigned ROM_ADDR_BITS = 10,
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write port
	input  logic                           cfg_wr_en,
	input  logic [zcsg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [zcsg_pkg::CFG_DATA_W-1:0] cfg_data,
	// Tick stream in
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,  // [0] restart, [7:1] zero
	input  logic                           s_tlast,  // block_end
	// Sample stream out
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [31:0]                    m_tdata,  // [15:0] sample_i, [31:16] sample_q
	output logic                           m_tlast   // block_last
);

	import zcsg_pkg::*;

	localparam int unsigned QUARTER = 1 << (ROM_ADDR_BITS - 2);
	localparam int unsigned QA_W = ROM_ADDR_BITS - 2;
	localparam int unsigned ENT_W = 30;
	localparam int unsigned DIV_STEPS = 32;
	localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);

	// Divider sequencer codes
	localparam logic [1:0] DIV_IDLE = 2'd0;
	localparam logic [1:0] DIV_REM  = 2'd1;
	localparam logic [1:0] DIV_QUO  = 2'd2;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [LEN_W-1:0]  seq_length_q;
	logic [IDX_W-1:0]  root_q;
	logic [IDX_W-1:0]  shift_q;
	logic [31:0]       step_q;
	logic [GAIN_W-1:0] gain_q;
	logic              len_wr;

	assign len_wr = cfg_wr_en && (cfg_index == REG_SEQ_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_length_q <= SEQ_LEN_RESET;
			root_q <= ROOT_RESET;
			shift_q <= '0;
			step_q <= '0;
			gain_q <= GAIN_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SEQ_LENGTH:   seq_length_q <= cfg_data[LEN_W-1:0];
				REG_ROOT_INDEX:   root_q <= cfg_data[IDX_W-1:0];
				REG_CYCLIC_SHIFT: shift_q <= cfg_data[IDX_W-1:0];
				REG_PHASE_STEP:   step_q <= cfg_data;
				REG_OUTPUT_GAIN:  gain_q <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Length clamped to 1..4096; both the modulo and the quotient use it.
	logic [LEN_W-1:0] len_eff;

	always_comb begin
		if (seq_length_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (seq_length_q > MAX_LEN) begin
			len_eff = MAX_LEN;
		end else begin
			len_eff = seq_length_q;
		end
	end

	// ------------------------------------------------------------------
	// Phasor RAM load after reset. The RAM holds the first quadrant only;
	// the other three are mirrored when the entry is read.
	// ------------------------------------------------------------------
	logic [ENT_W-1:0] qtab [QUARTER];

	for (genvar gk = 0; gk < QUARTER; gk++) begin : g_qtab
		localparam logic [ENT_W-1:0] ENTRY = zcsg_quarter_entry(gk, ROM_ADDR_BITS);
		assign qtab[gk] = ENTRY;
	end

	logic [QA_W-1:0] fill_idx_q;
	logic            fill_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_idx_q <= '0;
			fill_done_q <= 1'b0;
		end else if (!fill_done_q) begin
			fill_idx_q <= fill_idx_q + QA_W'(1);
			if (fill_idx_q == '1) begin
				fill_done_q <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tick acceptance: phase accumulator and symbol index.
	// index_q keeps the raw index as the sequence last left it; red_q is
	// the same index reduced modulo the current length, which is what the
	// next step builds on after a length change.
	// ------------------------------------------------------------------
	logic             adv;
	logic             acc;
	logic [31:0]      phase_q;
	logic [IDX_W-1:0] index_q;
	logic [IDX_W-1:0] red_q;
	logic             fresh_q;
	logic [31:0]      lq_q;
	logic [1:0]       div_st_q;
	logic [4:0]       div_cnt_q;
	logic [31:0]      div_dvd_q;
	logic [LEN_W-1:0] div_rem_q;

	logic             in_restart;
	logic [31:0]      ph_base;
	logic [32:0]      ph_sum;
	logic             wrap0;
	logic             fresh0;
	logic [IDX_W-1:0] red0;
	logic [LEN_W-1:0] red_inc;
	logic [IDX_W-1:0] n0;

	assign in_restart = s_tdata[0];
	assign ph_base = in_restart ? '1 : phase_q;
	assign ph_sum = {1'b0, ph_base} + {1'b0, step_q};
	assign wrap0 = ph_sum[32];
	assign fresh0 = in_restart || fresh_q;
	assign red0 = in_restart ? '0 : red_q;
	assign red_inc = {1'b0, red0} + LEN_W'(1);

	always_comb begin
		if (fresh0 || (red_inc == len_eff)) begin
			n0 = '0;
		end else begin
			n0 = red_inc[IDX_W-1:0];
		end
	end

	// The whole pipeline moves when the output register is free or drained.
	assign adv = !m_tvalid || m_tready;
	assign s_tready = fill_done_q && (div_st_q == DIV_IDLE) && !len_wr && adv;
	assign acc = s_tvalid && s_tready;

	// Shared restoring divider step: remainder first, then quotient.
	logic [LEN_W:0]   rem_sh;
	logic [LEN_W:0]   rem_diff;
	logic             rem_ge;
	logic [LEN_W-1:0] rem_nx;
	logic [31:0]      dvd_nx;
	logic             div_last;

	assign rem_sh = {div_rem_q, div_dvd_q[31]};
	assign rem_diff = rem_sh - {1'b0, len_eff};
	assign rem_ge = rem_sh >= {1'b0, len_eff};
	assign rem_nx = rem_ge ? rem_diff[LEN_W-1:0] : rem_sh[LEN_W-1:0];
	assign dvd_nx = {div_dvd_q[30:0], rem_ge};
	assign div_last = div_cnt_q == 5'(DIV_STEPS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '1;
			index_q <= '0;
			red_q <= '0;
			fresh_q <= 1'b1;
			lq_q <= LQ_RESET;
			div_st_q <= DIV_IDLE;
			div_cnt_q <= '0;
			div_dvd_q <= '0;
			div_rem_q <= '0;
		end else begin
			if (acc) begin
				phase_q <= ph_sum[31:0];
				if (wrap0) begin
					index_q <= n0;
					red_q <= n0;
					fresh_q <= 1'b0;
				end else if (in_restart) begin
					index_q <= '0;
					red_q <= '0;
					fresh_q <= 1'b1;
				end
			end

			if (len_wr) begin
				// A new length starts the divider from the raw index.
				div_st_q <= DIV_REM;
				div_cnt_q <= '0;
				div_dvd_q <= {{(32 - IDX_W){1'b0}}, index_q};
				div_rem_q <= '0;
			end else begin
				unique case (div_st_q)
					DIV_IDLE: ;
					DIV_REM: begin
						if (div_last) begin
							red_q <= rem_nx[IDX_W-1:0];
							div_st_q <= DIV_QUO;
							div_cnt_q <= '0;
							div_dvd_q <= DIVIDEND[31:0];
							div_rem_q <= '0;
						end else begin
							div_cnt_q <= div_cnt_q + 5'd1;
							div_dvd_q <= dvd_nx;
							div_rem_q <= rem_nx;
						end
					end
					DIV_QUO: begin
						if (div_last) begin
							lq_q <= dvd_nx;
							div_st_q <= DIV_IDLE;
						end else begin
							div_cnt_q <= div_cnt_q + 5'd1;
							div_dvd_q <= dvd_nx;
							div_rem_q <= rem_nx;
						end
					end
					default: div_st_q <= DIV_IDLE;
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Chip pipeline. Every beat flows through it so that order is kept;
	// only beats marked wrap or restart change the held sample at the end.
	// ------------------------------------------------------------------
	logic      v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	zcsg_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;

	logic [IDX_W-1:0]         n_s1;
	logic [2*IDX_W-1:0]       a_s2;
	logic [TERM_W-1:0]        b_s2;
	logic [31:0]              p1_s3;
	logic [31:0]              p2_s4;
	logic [1:0]               quad_s5;
	logic signed [PROD_W-1:0] pi_s6;
	logic signed [PROD_W-1:0] pq_s6;

	// Stage 1: u*n and the bracket term n + (L mod 2) + 2q.
	logic [2*IDX_W-1:0] a1;
	logic [TERM_W-1:0]  b1;

	assign a1 = root_q * n_s1;
	assign b1 = {2'b00, n_s1} + {{(TERM_W - 1){1'b0}}, len_eff[0]} + {1'b0, shift_q, 1'b0};

	// Stage 2: full product modulo 2^32.
	logic [2*IDX_W+TERM_W-1:0] p1_full;

	assign p1_full = a_s2 * b_s2;

	// Stage 3: scale by the length quotient, low 32 bits.
	logic [31:0] p2;

	assign p2 = p1_s3 * lq_q;

	// Stage 4: negate, take the top address bits and read the RAM.
	logic [31:0]              p_neg;
	logic [ROM_ADDR_BITS-1:0] rom_addr;
	logic [ENT_W-1:0]         ent_s5;

	assign p_neg = 32'd0 - p2_s4;
	assign rom_addr = p_neg[31 -: ROM_ADDR_BITS];

	zcsg_ram #(
		.WIDTH (ENT_W),
		.DEPTH (QUARTER)
	) u_phasor_ram (
		.clk     (clk),
		.wr_en   (!fill_done_q),
		.wr_addr (fill_idx_q),
		.wr_data (qtab[fill_idx_q]),
		.rd_en   (adv),
		.rd_addr (rom_addr[QA_W-1:0]),
		.rd_data (ent_s5)
	);

	// Stage 5: mirror by quadrant and apply the gain.
	logic signed [OUT_W-1:0] cos_v;
	logic signed [OUT_W-1:0] sin_v;
	logic signed [OUT_W-1:0] ph_i;
	logic signed [OUT_W-1:0] ph_q;

	assign cos_v = {1'b0, ent_s5[14:0]};
	assign sin_v = {1'b0, ent_s5[29:15]};

	always_comb begin
		case (quad_s5)
			2'd0: begin
				ph_i = cos_v;
				ph_q = sin_v;
			end
			2'd1: begin
				ph_i = -sin_v;
				ph_q = cos_v;
			end
			2'd2: begin
				ph_i = -cos_v;
				ph_q = -sin_v;
			end
			default: begin
				ph_i = sin_v;
				ph_q = -cos_v;
			end
		endcase
	end

	logic signed [PROD_W-1:0] prod_i;
	logic signed [PROD_W-1:0] prod_q;

	assign prod_i = ph_i * $signed({1'b0, gain_q});
	assign prod_q = ph_q * $signed({1'b0, gain_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1 <= '{wrap: wrap0, restart: in_restart, last: s_tlast};
			n_s1 <= n0;
			ctl_s2 <= ctl_s1;
			a_s2 <= a1;
			b_s2 <= b1;
			ctl_s3 <= ctl_s2;
			p1_s3 <= p1_full[31:0];
			ctl_s4 <= ctl_s3;
			p2_s4 <= p2;
			ctl_s5 <= ctl_s4;
			quad_s5 <= rom_addr[ROM_ADDR_BITS-1 -: 2];
			ctl_s6 <= ctl_s5;
			pi_s6 <= prod_i;
			pq_s6 <= prod_q;
		end
	end

	// Stage 6: saturate into the output register, which is also the held sample.
	logic signed [PROD_W-1:0] sat_i;
	logic signed [PROD_W-1:0] sat_q;

	always_comb begin
		if (pi_s6 > SAT_HI) begin
			sat_i = SAT_HI;
		end else if (pi_s6 < SAT_LO) begin
			sat_i = SAT_LO;
		end else begin
			sat_i = pi_s6;
		end
		if (pq_s6 > SAT_HI) begin
			sat_q = SAT_HI;
		end else if (pq_s6 < SAT_LO) begin
			sat_q = SAT_LO;
		end else begin
			sat_q = pq_s6;
		end
	end

	logic              m_tvalid_q;
	logic              m_tlast_q;
	logic [OUT_W-1:0]  held_i_q;
	logic [OUT_W-1:0]  held_q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			m_tlast_q <= 1'b0;
			held_i_q <= '0;
			held_q_q <= '0;
		end else if (adv) begin
			m_tvalid_q <= v_s6;
			if (v_s6) begin
				m_tlast_q <= ctl_s6.last;
				if (ctl_s6.wrap) begin
					held_i_q <= sat_i[OUT_W-1:0];
					held_q_q <= sat_q[OUT_W-1:0];
				end else if (ctl_s6.restart) begin
					held_i_q <= '0;
					held_q_q <= '0;
				end
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast = m_tlast_q;
	assign m_tdata = {held_q_q, held_i_q};

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------

	// Once the divider is idle the reduced index is inside the sequence.
	assert property (@(posedge clk) disable iff (!arst_n)
		(div_st_q == DIV_IDLE) |-> ({1'b0, red_q} < len_eff))
		else $error("reduced symbol index not below the sequence length");

	// The length quotient stays between 2^31/4096 and 2^31.
	assert property (@(posedge clk) disable iff (!arst_n)
		(div_st_q == DIV_IDLE) |-> ((lq_q >= 32'h0008_0000) && (lq_q <= 32'h8000_0000)))
		else $error("length quotient out of range");

	// A fresh sequence starts from index zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q |-> ((index_q == '0) && (red_q == '0)))
		else $error("fresh sequence with nonzero index");

	// Nothing is in flight while the phasor RAM is still being loaded.
	assert property (@(posedge clk) disable iff (!arst_n)
		!fill_done_q |-> !(v_s1 || v_s2 || v_s3 || v_s4 || v_s5 || v_s6 || m_tvalid_q))
		else $error("beat in flight during phasor load");

	// A beat that neither wraps nor restarts leaves the held sample alone.
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s6 && !ctl_s6.wrap && !ctl_s6.restart) |=> $stable(m_tdata))
		else $error("held sample changed without a wrap or restart");

endmodule

>>> test/zadoff_chu_sequence_generator_core_tb.sv
// Self-checking testbench for zadoff_chu_sequence_generator_core.
// It predicts every output beat with its own model of the chip arithmetic and phasor table.
// Depends on zcsg_pkg and the core RTL only; it reads no files.
`timescale 1ns / 100ps

module zadoff_chu_sequence_generator_core_tb;
	import zcsg_pkg::*;

	// The core is built with its default sizes, so the predictor uses the same ones.
	localparam int unsigned ADDR_BITS = 10;
	localparam int unsigned TABLE_SIZE = 1 << ADDR_BITS;
	localparam longint unsigned PI_Q30_FX = 64'd3373259426;
	localparam int unsigned SERIES_TERMS = 12;
	localparam int unsigned LONGEST_LEN = 4096;

	// Indexes 5 to 7 are decoded by nobody; writes there must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

	localparam int unsigned RANDOM_PHASES = 14;
	localparam int unsigned TICKS_PER_PHASE = 75;
	localparam int unsigned HOLD_PHASE = 5;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam longint unsigned CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic restart;
		logic block_end;
	} tick_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] i;
		logic signed [OUT_W-1:0] q;
		logic                    last;
	} sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic m_tlast;

	zadoff_chu_sequence_generator_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Ticks waiting to be offered, and samples the core still owes us, oldest first.
	tick_t tick_queue[$];
	sample_t sample_queue[$];
	tick_t tick_on_bus;
	sample_t owed;

	// Idling knobs, set per phase by the stimulus process, in percent of cycles.
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	logic hold_active = 1'b0;
	int unsigned hold_count = 0;

	int unsigned fail_count = 0;
	longint unsigned cycle_count = 0;

	// Predictor copy of the register file.
	logic [LEN_W-1:0] len_reg;
	logic [IDX_W-1:0] root_reg;
	logic [IDX_W-1:0] shift_reg;
	logic [31:0] step_reg;
	logic [GAIN_W-1:0] gain_reg;

	// Predictor copy of the running state.
	logic [31:0] acc;
	int unsigned sym_idx;
	logic idx_fresh;
	logic signed [OUT_W-1:0] held_i;
	logic signed [OUT_W-1:0] held_q;
	logic [31:0] len_quot;
	logic signed [OUT_W-1:0] cos_tab[TABLE_SIZE];
	logic signed [OUT_W-1:0] sin_tab[TABLE_SIZE];

	// Rounds a Q30 value to Q15; negative values clamp to zero and the top to 32767.
	function automatic logic signed [OUT_W-1:0] q30_round(longint v);
		longint r;
		if (v < 0) begin
			r = 0;
		end else begin
			r = (v + 16384) / 32768;
		end
		if (r > 32767) begin
			r = 32767;
		end
		return 16'(r);
	endfunction

	// The table is one quadrant of Taylor series computed in Q30 and rounded to Q15, mirrored into the other three.
	function automatic void build_phasor_table();
		int unsigned k;
		int unsigned j;
		int unsigned quad;
		int unsigned r;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned tc;
		longint unsigned ts;
		longint sc;
		longint ss;
		logic signed [OUT_W-1:0] c;
		logic signed [OUT_W-1:0] s;
		for (k = 0; k < TABLE_SIZE; k++) begin
			quad = k / (TABLE_SIZE / 4);
			r = k % (TABLE_SIZE / 4);
			x = (PI_Q30_FX * 64'(r)) >> (ADDR_BITS - 1);
			x2 = (x * x) >> 30;
			tc = 64'd1 << 30;
			ts = x;
			sc = 0;
			ss = 0;
			for (j = 0; j < SERIES_TERMS; j++) begin
				if ((j % 2) == 0) begin
					sc = sc + longint'(tc);
					ss = ss + longint'(ts);
				end else begin
					sc = sc - longint'(tc);
					ss = ss - longint'(ts);
				end
				tc = ((tc * x2) >> 30) / 64'((2 * j + 1) * (2 * j + 2));
				ts = ((ts * x2) >> 30) / 64'((2 * j + 2) * (2 * j + 3));
			end
			c = q30_round(sc);
			s = q30_round(ss);
			case (quad)
				0: begin
					cos_tab[k] = c;
					sin_tab[k] = s;
				end
				1: begin
					cos_tab[k] = -s;
					sin_tab[k] = c;
				end
				2: begin
					cos_tab[k] = -c;
					sin_tab[k] = -s;
				end
				default: begin
					cos_tab[k] = s;
					sin_tab[k] = -c;
				end
			endcase
		end
	endfunction

	// Length zero acts as one and anything past 4096 as 4096.
	function automatic int unsigned eff_length();
		if (len_reg == 0) begin
			return 1;
		end
		if (len_reg > LONGEST_LEN) begin
			return LONGEST_LEN;
		end
		return int'(len_reg);
	endfunction

	function automatic logic signed [OUT_W-1:0] scale_gain(logic signed [OUT_W-1:0] v);
		longint prod;
		prod = longint'(v) * longint'(gain_reg);
		if (prod > 32767) begin
			prod = 32767;
		end
		if (prod < -32768) begin
			prod = -32768;
		end
		return 16'(prod);
	endfunction

	function automatic void clear_run();
		acc = '1;
		sym_idx = 0;
		idx_fresh = 1'b1;
		held_i = '0;
		held_q = '0;
	endfunction

	function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		case (idx)
			REG_SEQ_LENGTH: begin
				len_reg = data[LEN_W-1:0];
				len_quot = 32'((64'd1 << 31) / eff_length());
			end
			REG_ROOT_INDEX: root_reg = data[IDX_W-1:0];
			REG_CYCLIC_SHIFT: shift_reg = data[IDX_W-1:0];
			REG_PHASE_STEP: step_reg = data;
			REG_OUTPUT_GAIN: gain_reg = data[GAIN_W-1:0];
			default: ;
		endcase
	endfunction

	// Advances the generator by one tick and returns the sample it puts out.
	// A carry out of the phase accumulator starts a new chip at angle
	// -pi*u*n*(n + L mod 2 + 2q)/L, reached through the precomputed quotient.
	function automatic sample_t advance_generator(tick_t t);
		logic [32:0] sum;
		int unsigned len;
		logic [31:0] n;
		logic [31:0] term;
		logic [31:0] p;
		logic [ADDR_BITS-1:0] addr;
		sample_t res;
		if (t.restart) begin
			clear_run();
		end
		sum = {1'b0, acc} + {1'b0, step_reg};
		acc = sum[31:0];
		if (sum[32]) begin
			len = eff_length();
			if (idx_fresh) begin
				sym_idx = 0;
			end else begin
				sym_idx = (sym_idx + 1) % len;
			end
			idx_fresh = 1'b0;
			n = sym_idx;
			term = n + (len & 1) + 2 * shift_reg;
			p = root_reg * n;
			p = p * term;
			p = p * len_quot;
			p = 32'd0 - p;
			addr = p[31 -: ADDR_BITS];
			held_i = scale_gain(cos_tab[addr]);
			held_q = scale_gain(sin_tab[addr]);
		end
		res.i = held_i;
		res.q = held_q;
		res.last = t.block_end;
		return res;
	endfunction

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	// Timeout guard: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Driver: offers queued ticks, keeping a beat steady until it is taken.
	// The expected sample is worked out at the edge where the beat is accepted.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				sample_queue.push_back(advance_generator(tick_on_bus));
			end
			if (!s_tvalid || s_tready) begin
				if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					tick_on_bus = tick_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {7'd0, tick_on_bus.restart};
					s_tlast <= tick_on_bus.block_end;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: drives m_tready and checks each accepted output beat against the
	// oldest owed sample. In the hold phase it first keeps m_tready low for a
	// long stretch so the core backs up and drops s_tready.
	always @(posedge clk) begin
		if (hold_active && hold_count < HOLD_CYCLES) begin
			m_tready <= 1'b0;
			hold_count <= hold_count + 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (sample_queue.size() == 0) begin
				$error("output beat with no sample owed: data %h last %b", m_tdata, m_tlast);
				fail_count++;
			end else begin
				owed = sample_queue.pop_front();
				if (m_tdata[15:0] !== owed.i) begin
					$error("sample_i mismatch: expected %0d, actual %0d",
						owed.i, $signed(m_tdata[15:0]));
					fail_count++;
				end
				if (m_tdata[31:16] !== owed.q) begin
					$error("sample_q mismatch: expected %0d, actual %0d",
						owed.q, $signed(m_tdata[31:16]));
					fail_count++;
				end
				if (m_tlast !== owed.last) begin
					$error("block_last mismatch: expected %0b, actual %0b", owed.last, m_tlast);
					fail_count++;
				end
			end
		end
	end

	// Waits until every queued tick has gone in and every owed sample has come out.
	task automatic wait_idle();
		while (tick_queue.size() != 0 || sample_queue.size() != 0 || s_tvalid) begin
			@(posedge clk);
		end
	endtask

	// One register write; the predictor takes it at the same time, since the core is idle.
	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		apply_reg_write(idx, data);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_all(logic [31:0] len, logic [31:0] root, logic [31:0] shift,
			logic [31:0] step, logic [31:0] gain);
		wait_idle();
		cfg_write(REG_SEQ_LENGTH, len);
		cfg_write(REG_ROOT_INDEX, root);
		cfg_write(REG_CYCLIC_SHIFT, shift);
		cfg_write(REG_PHASE_STEP, step);
		cfg_write(REG_OUTPUT_GAIN, gain);
	endtask

	task automatic push_tick(logic restart, logic block_end);
		tick_t t;
		t.restart = restart;
		t.block_end = block_end;
		tick_queue.push_back(t);
	endtask

	// Picks one random register setting, weighted toward short sequences so the
	// symbol index wraps around often, with the extremes mixed in.
	task automatic random_setting();
		logic [31:0] len;
		logic [31:0] step;
		logic [31:0] gain;
		int unsigned pick;
		pick = $urandom_range(9);
		if (pick < 6) begin
			len = $urandom_range(1, 64);
		end else if (pick < 8) begin
			len = $urandom_range(65, LONGEST_LEN);
		end else if (pick == 8) begin
			case ($urandom_range(3))
				0: len = 0;
				1: len = 1;
				2: len = LONGEST_LEN;
				default: len = 32'h1FFF;
			endcase
		end else begin
			len = $urandom_range(LONGEST_LEN + 1, 8191);
		end
		pick = $urandom_range(9);
		if (pick < 5) begin
			step = $urandom;
		end else if (pick < 8) begin
			step = $urandom_range(32'hFFFF_FFFF, 32'hC000_0000);
		end else if (pick == 8) begin
			case ($urandom_range(2))
				0: step = 32'd0;
				1: step = 32'h8000_0000;
				default: step = 32'hFFFF_FFFF;
			endcase
		end else begin
			step = $urandom_range(32'h0800_0000);
		end
		case ($urandom_range(4))
			0: gain = 0;
			1: gain = 1;
			2: gain = 255;
			default: gain = $urandom_range(255);
		endcase
		// Bits above each register's width are junk that the core must drop.
		set_all(32'({$urandom, 13'd0} | len), 32'({$urandom, 12'd0} | $urandom_range(4095)),
			($urandom_range(3) == 0) ? 32'd0 : 32'({$urandom, 12'd0} | $urandom_range(4095)),
			step, 32'({$urandom, 8'd0} | gain));
	endtask

	int unsigned ph;
	int unsigned k;

	initial begin
		build_phasor_table();
		apply_reg_write(REG_SEQ_LENGTH, 32'(SEQ_LEN_RESET));
		apply_reg_write(REG_ROOT_INDEX, 32'(ROOT_RESET));
		apply_reg_write(REG_CYCLIC_SHIFT, 32'd0);
		apply_reg_write(REG_PHASE_STEP, 32'd0);
		apply_reg_write(REG_OUTPUT_GAIN, 32'(GAIN_RESET));
		clear_run();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// The core fills its phasor table before it takes its first beat.
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end

		// Reset settings have a zero phase step: no wrap, so the held sample stays zero.
		push_tick(1'b0, 1'b0);
		push_tick(1'b1, 1'b1);
		push_tick(1'b0, 1'b1);

		// Length zero acts as one, so every chip is index zero; full gain saturates.
		set_all(32'd0, 32'd4095, 32'd4095, 32'hFFFF_FFFF, 32'd255);
		push_tick(1'b1, 1'b0);
		push_tick(1'b0, 1'b0);
		push_tick(1'b0, 1'b1);
		push_tick(1'b0, 1'b0);

		// Largest length field saturates to 4096; zero gain mutes the output.
		set_all(32'h1FFF, 32'd4095, 32'd0, 32'h8000_0000, 32'd0);
		push_tick(1'b0, 1'b0);
		push_tick(1'b0, 1'b1);
		push_tick(1'b0, 1'b0);

		// A full-scale step wraps nearly every tick, walking the index upward.
		set_all(32'd40, 32'd3, 32'd2, 32'hFFFF_FFFF, 32'd2);
		push_tick(1'b1, 1'b0);
		for (k = 0; k < 6; k++) begin
			push_tick(1'b0, k[0]);
		end
		push_tick(1'b0, 1'b1);
		push_tick(1'b0, 1'b0);

		// Shrinking the length with no restart carries an index past the new length;
		// the next chip folds it back into range at once.
		// Writes to unmapped indexes must leave every register alone.
		set_all(32'd3, 32'd5, 32'd1, 32'hFFFF_FFFF, 32'd200);
		for (k = 32'(REG_UNMAPPED_LO); k <= 32'(REG_UNMAPPED_HI); k++) begin
			cfg_write(CFG_IDX_W'(k), $urandom);
		end
		push_tick(1'b0, 1'b0);
		push_tick(1'b0, 1'b1);
		push_tick(1'b0, 1'b0);

		// Random phases rotate through the idling modes; one phase also stalls the
		// receiver long enough for the core to fill and hold off its input.
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			random_setting();
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 85;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 85;
				end
				default: begin
					send_idle_pct = 17;
					recv_stall_pct = 17;
				end
			endcase
			if (ph == HOLD_PHASE) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
				hold_active = 1'b1;
			end
			for (k = 0; k < TICKS_PER_PHASE; k++) begin
				push_tick((k == 0 && $urandom_range(2) == 0) || $urandom_range(99) < 2,
					$urandom_range(7) == 0);
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sample_queue.size() != 0) begin
			$error("%0d samples never came out", sample_queue.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
